[sv/triple_lens_ray_hit_test_unit_assert.svh]
// Assertion macros for the triple lens ray hit test unit.
// Needs no other file; the macros expand to nothing when SYNTH is defined.
`ifndef TRIPLE_LENS_RAY_HIT_TEST_UNIT_ASSERT_SVH
`define TRIPLE_LENS_RAY_HIT_TEST_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TLRH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlrh assertion failed");
`define TLRH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlrh assertion failed");
`else
`define TLRH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TLRH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/tlrh_pkg.sv]
// Shared widths, types and codes of the triple lens ray hit test unit.
// No dependencies.
`default_nettype none
package tlrh_pkg;
  localparam int FracBits = 24;
  localparam int CoordW   = 32;
  localparam int MassW    = 25;
  localparam int PosW     = 64;
  localparam int EnvW     = 32;
  localparam int MagW     = CoordW;
  localparam int SqW      = 2 * CoordW;
  localparam int D2W      = SqW - FracBits;
  localparam int QW       = CoordW - 1;
  localparam int NumW     = FracBits + CoordW;
  localparam int CmpW     = D2W + QW;
  localparam int NumLens  = 3;
  localparam int PrepLat  = 3;
  localparam int DivLat   = QW;
  localparam int HitLat   = 3;
  localparam int PipeLat  = PrepLat + DivLat + 1 + HitLat;
  localparam int CfgIdxW  = 3;
  localparam logic [MassW-1:0]  MassOne = MassW'(1) << FracBits;
  localparam logic [CoordW-1:0] TermMax = {1'b0, {(CoordW-1){1'b1}}};

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   ext_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMassOne   = 3'd0,
    CfgMassTwo   = 3'd1,
    CfgMassThree = 3'd2,
    CfgLensOne   = 3'd3,
    CfgLensTwo   = 3'd4,
    CfgLensThree = 3'd5,
    CfgEnvRadSq  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TermZero,
    TermSat,
    TermDiv
  } term_kind_e;

  typedef struct packed {
    term_kind_e kind_x;
    term_kind_e kind_y;
    logic       neg_x;
    logic       neg_y;
    logic       sat;
  } lens_info_t;

  typedef struct packed {
    lens_info_t [NumLens-1:0] info;
    ext_t                     bx;
    ext_t                     by;
  } side_t;
endpackage
`default_nettype wire

[sv/tlrh_lens_prep.sv]
// Per-lens front end: offsets, squares, numerators, radius and term class.
// Depends on tlrh_pkg. Three register stages.
`default_nettype none
module tlrh_lens_prep import tlrh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire coord_t           px_i,
  input  wire coord_t           py_i,
  input  wire logic [MassW-1:0] mass_i,
  input  wire logic [PosW-1:0]  pos_i,
  output logic [NumW-1:0]       num_x_o,
  output logic [NumW-1:0]       num_y_o,
  output logic [D2W-1:0]        d2_o,
  output lens_info_t            info_o
);
  ext_t raw_x, raw_y;
  coord_t dx_d, dy_d, dx_q, dy_q;
  logic [MassW-1:0] m_c;
  logic [MagW-1:0]  mag_x, mag_y;
  logic [MassW+MagW-1:0] prod_x, prod_y;
  logic [SqW-1:0]   sqx_q, sqy_q, sum;
  logic [NumW-1:0]  numx_q, numy_q;
  logic             zx_q, zy_q, nx_q, ny_q;
  logic [D2W-1:0]   d2;
  logic             ovf_x, ovf_y, d2z;
  lens_info_t       info_d;

  // stage 1: offsets clamped to 32 bits
  always_comb begin
    raw_x = $signed({px_i[CoordW-1], px_i}) -
            $signed({pos_i[PosW-1], pos_i[PosW-1:CoordW]});
    raw_y = $signed({py_i[CoordW-1], py_i}) -
            $signed({pos_i[CoordW-1], pos_i[CoordW-1:0]});
    dx_d = (raw_x[CoordW] != raw_x[CoordW-1]) ?
           (raw_x[CoordW] ? ~TermMax : TermMax) : raw_x[CoordW-1:0];
    dy_d = (raw_y[CoordW] != raw_y[CoordW-1]) ?
           (raw_y[CoordW] ? ~TermMax : TermMax) : raw_y[CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // stage 2: squares and mass-weighted magnitudes
  always_comb begin
    m_c    = (mass_i > MassOne) ? MassOne : mass_i;
    mag_x  = dx_q[CoordW-1] ? (~dx_q + 1'b1) : dx_q;
    mag_y  = dy_q[CoordW-1] ? (~dy_q + 1'b1) : dy_q;
    prod_x = m_c * mag_x;
    prod_y = m_c * mag_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q  <= SqW'(dx_q * dx_q);
      sqy_q  <= SqW'(dy_q * dy_q);
      numx_q <= NumW'(prod_x);
      numy_q <= NumW'(prod_y);
      zx_q   <= (dx_q == '0) || (m_c == '0);
      zy_q   <= (dy_q == '0) || (m_c == '0);
      nx_q   <= dx_q[CoordW-1];
      ny_q   <= dy_q[CoordW-1];
    end
  end

  // stage 3: radius squared and term classification
  always_comb begin
    sum   = sqx_q + sqy_q;
    d2    = sum[SqW-1:FracBits];
    d2z   = (d2 == '0);
    ovf_x = D2W'(numx_q >> QW) >= d2;
    ovf_y = D2W'(numy_q >> QW) >= d2;
    info_d.kind_x = zx_q ? TermZero : ((d2z || ovf_x) ? TermSat : TermDiv);
    info_d.kind_y = zy_q ? TermZero : ((d2z || ovf_y) ? TermSat : TermDiv);
    info_d.neg_x  = nx_q;
    info_d.neg_y  = ny_q;
    info_d.sat    = (d2z && (mass_i != '0)) || (!zx_q && (d2z || ovf_x)) ||
                    (!zy_q && (d2z || ovf_y));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_x_o <= numx_q;
      num_y_o <= numy_q;
      d2_o    <= d2;
      info_o  <= info_d;
    end
  end
endmodule
`default_nettype wire

[sv/tlrh_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tlrh_pkg. Quotient valid only when it fits in QW bits.
`default_nettype none
module tlrh_div import tlrh_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [D2W-1:0]  den_i,
  output logic [QW-1:0]        quo_o
);
  logic [NumW-1:0] rem_q [QW];
  logic [D2W-1:0]  den_q [QW];
  logic [QW-1:0]   quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int Bit = QW - 1 - k;
    logic [NumW-1:0] rin;
    logic [D2W-1:0]  din;
    logic [QW-1:0]   qin;
    logic [CmpW-1:0] trial;
    logic            ge;
    if (k == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end
    assign trial = CmpW'(din) << Bit;
    assign ge    = CmpW'(rin) >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? NumW'(CmpW'(rin) - trial) : rin;
        den_q[k] <= din;
        quo_q[k] <= qin | (QW'(ge) << Bit);
      end
    end
  end

  assign quo_o = quo_q[QW-1];
endmodule
`default_nettype wire

[sv/tlrh_hit_test.sv]
// Back end: mapped offset from source, squares and envelope compare.
// Depends on tlrh_pkg. Three register stages, the last is the output register.
`default_nettype none
module tlrh_hit_test import tlrh_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire ext_t                      bx_i,
  input  wire ext_t                      by_i,
  input  wire coord_t [NumLens-1:0]      tx_i,
  input  wire coord_t [NumLens-1:0]      ty_i,
  input  wire logic                      sat_i,
  input  wire logic [EnvW-1:0]           env_i,
  output logic                           hit_o,
  output logic                           sat_o
);
  logic signed [CoordW+2:0] ex, ey;
  logic [CoordW-1:0] ax_q, ay_q;
  logic              inr_q, inr2_q, sat1_q, sat2_q;
  logic [SqW-1:0]    a_q, b_q;
  logic [EnvW+FracBits-1:0] lim;
  logic [SqW:0]      ab;

  always_comb begin
    ex = (CoordW+3)'(bx_i) - (CoordW+3)'(tx_i[0]) - (CoordW+3)'(tx_i[1])
         - (CoordW+3)'(tx_i[2]);
    ey = (CoordW+3)'(by_i) - (CoordW+3)'(ty_i[0]) - (CoordW+3)'(ty_i[1])
         - (CoordW+3)'(ty_i[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= CoordW'(ex[CoordW+2] ? -ex : ex);
      ay_q   <= CoordW'(ey[CoordW+2] ? -ey : ey);
      // in range when |e| < 2^32
      inr_q  <= (ex[CoordW+2:CoordW] == '0 || ex[CoordW+2:CoordW] == '1) &&
                !(ex[CoordW+2:CoordW] == '1 && ex[CoordW-1:0] == '0) &&
                (ey[CoordW+2:CoordW] == '0 || ey[CoordW+2:CoordW] == '1) &&
                !(ey[CoordW+2:CoordW] == '1 && ey[CoordW-1:0] == '0);
      sat1_q <= sat_i;
      a_q    <= ax_q * ax_q;
      b_q    <= ay_q * ay_q;
      inr2_q <= inr_q;
      sat2_q <= sat1_q;
    end
  end

  always_comb begin
    lim = {env_i, {FracBits{1'b0}}};
    ab  = {1'b0, a_q} + {1'b0, b_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= inr2_q && (a_q <= SqW'(lim)) && (b_q <= SqW'(lim)) &&
               (ab <= (SqW+1)'(lim));
      sat_o <= sat2_q;
    end
  end
endmodule
`default_nettype wire

[sv/triple_lens_ray_hit_test_unit.sv]
// Triple point-lens ray shooting hit test, streaming top level.
// Uses tlrh_pkg, tlrh_lens_prep, tlrh_div, tlrh_hit_test and the assert header.
//
// Input stream s_axis: one beat is a pixel and the current source center,
// all signed Q8.24. Output stream m_axis: one beat per input beat, in order,
// carrying hit and saturated flags.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (masses, lens positions, envelope radius squared); unknown indexes are
// dropped. Write only while the pipe is empty.
// Pipeline from input beat to output beat: 3 front-end stages, 31 divider
// stages of one quotient bit each, one term select stage, 3 back-end stages
// ending in the output register.
// Throughput: one beat per cycle while the output is not stalled; the 31-bit
// pipelined dividers, six of them (two per lens), set the depth.
// Reset clears all valid bits and loads the register reset values
// (mass one = 1.0, all else 0). A stalled m_axis freezes the whole pipe
// only while the output register is full; bubbles keep draining.
`default_nettype none
`include "triple_lens_ray_hit_test_unit_assert.svh"
module triple_lens_ray_hit_test_unit import tlrh_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [PosW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // pixel_x [31:0], pixel_y [63:32], source_x [95:64], source_y [127:96]
  input  wire logic [4*CoordW-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // hit [0], saturated [1], zero fill [7:2]
  output logic [7:0]               m_axis_tdata
);
  logic [MassW-1:0] mass_q [NumLens];
  logic [PosW-1:0]  pos_q  [NumLens];
  logic [EnvW-1:0]  env_q;
  logic [PipeLat-1:0] vld_q;
  logic en;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q[0] <= MassOne;
      mass_q[1] <= '0;
      mass_q[2] <= '0;
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pos_q[2]  <= '0;
      env_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMassOne:   mass_q[0] <= cfg_data_i[MassW-1:0];
        CfgMassTwo:   mass_q[1] <= cfg_data_i[MassW-1:0];
        CfgMassThree: mass_q[2] <= cfg_data_i[MassW-1:0];
        CfgLensOne:   pos_q[0]  <= cfg_data_i;
        CfgLensTwo:   pos_q[1]  <= cfg_data_i;
        CfgLensThree: pos_q[2]  <= cfg_data_i;
        CfgEnvRadSq:  env_q     <= cfg_data_i[EnvW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: pipe moves unless a full output register is stalled
  assign en            = !vld_q[PipeLat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PipeLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], s_axis_tvalid};
    end
  end

  coord_t px, py, sx, sy;
  assign px = s_axis_tdata[CoordW-1:0];
  assign py = s_axis_tdata[2*CoordW-1:CoordW];
  assign sx = s_axis_tdata[3*CoordW-1:2*CoordW];
  assign sy = s_axis_tdata[4*CoordW-1:3*CoordW];

  // pixel minus source travels alongside the lens front ends
  ext_t bx_q [PrepLat];
  ext_t by_q [PrepLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q[0] <= $signed({px[CoordW-1], px}) - $signed({sx[CoordW-1], sx});
      by_q[0] <= $signed({py[CoordW-1], py}) - $signed({sy[CoordW-1], sy});
      for (int i = 1; i < PrepLat; i++) begin
        bx_q[i] <= bx_q[i-1];
        by_q[i] <= by_q[i-1];
      end
    end
  end

  logic [NumW-1:0] num_x [NumLens];
  logic [NumW-1:0] num_y [NumLens];
  logic [D2W-1:0]  d2    [NumLens];
  logic [QW-1:0]   qx    [NumLens];
  logic [QW-1:0]   qy    [NumLens];
  side_t           side_d;
  side_t           side_q [DivLat];

  for (genvar l = 0; l < NumLens; l++) begin : g_lens
    tlrh_lens_prep u_prep (
      .clk_i   (clk_i),
      .en_i    (en),
      .px_i    (px),
      .py_i    (py),
      .mass_i  (mass_q[l]),
      .pos_i   (pos_q[l]),
      .num_x_o (num_x[l]),
      .num_y_o (num_y[l]),
      .d2_o    (d2[l]),
      .info_o  (side_d.info[l])
    );
    tlrh_div u_div_x (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_x[l]),
      .den_i (d2[l]),
      .quo_o (qx[l])
    );
    tlrh_div u_div_y (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_y[l]),
      .den_i (d2[l]),
      .quo_o (qy[l])
    );
  end

  assign side_d.bx = bx_q[PrepLat-1];
  assign side_d.by = by_q[PrepLat-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DivLat; i++) side_q[i] <= side_q[i-1];
    end
  end

  // term select: zero, clamped, or quotient, then sign
  function automatic coord_t pick_term(term_kind_e kind, logic neg, logic [QW-1:0] q);
    coord_t mag;
    unique case (kind)
      TermZero: mag = '0;
      TermSat:  mag = TermMax;
      TermDiv:  mag = {1'b0, q};
      default:  mag = '0;
    endcase
    return neg ? -mag : mag;
  endfunction

  side_t  last;
  coord_t [NumLens-1:0] tx_q, ty_q;
  ext_t   bx_s_q, by_s_q;
  logic   sat_s_q;
  assign last = side_q[DivLat-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NumLens; l++) begin
        tx_q[l] <= pick_term(last.info[l].kind_x, last.info[l].neg_x, qx[l]);
        ty_q[l] <= pick_term(last.info[l].kind_y, last.info[l].neg_y, qy[l]);
      end
      sat_s_q <= last.info[0].sat || last.info[1].sat || last.info[2].sat;
      bx_s_q  <= last.bx;
      by_s_q  <= last.by;
    end
  end

  logic hit, sat;
  tlrh_hit_test u_hit (
    .clk_i (clk_i),
    .en_i  (en),
    .bx_i  (bx_s_q),
    .by_i  (by_s_q),
    .tx_i  (tx_q),
    .ty_i  (ty_q),
    .sat_i (sat_s_q),
    .env_i (env_q),
    .hit_o (hit),
    .sat_o (sat)
  );

  assign m_axis_tdata = {6'b0, sat, hit};

  // an accepted beat enters the first stage
  `TLRH_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0])
  // a beat in the last inner stage reaches the output register when the pipe moves
  `TLRH_ASSERT_NEXT(a_reach_out, clk_i, rst_ni, vld_q[PipeLat-2] && en, m_axis_tvalid)
  // a clamped term of the first lens is always flagged
  `TLRH_ASSERT_IMPL(a_clamp_flag, clk_i, rst_ni, last.info[0].kind_x == TermSat || last.info[0].kind_y == TermSat, last.info[0].sat)
endmodule
`default_nettype wire

[sim/triple_lens_ray_hit_test_unit_test.sv]
// Self-checking testbench for triple_lens_ray_hit_test_unit.
// Depends on tlrh_pkg and the unit under test; drives random stalls on both streams.
`timescale 1ns / 100ps
`default_nettype none
module triple_lens_ray_hit_test_unit_test;
  import tlrh_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;  // unmapped index, write dropped
  localparam int DrainCycles = PipeLat + 8;
  localparam int Phases      = 8;
  localparam int PhaseItems  = 200;

  typedef struct packed {
    logic hit;
    logic sat;
  } flags_t;

  typedef struct {
    logic [31:0] px, py, sx, sy;
    bit          typed;  // expected flags given in the row
    flags_t      flags;
  } pixel_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [PosW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // pixel_x [31:0], pixel_y [63:32], source_x [95:64], source_y [127:96]
  logic [4*CoordW-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // hit [0], saturated [1], zero fill [7:2]
  logic [7:0]          m_axis_tdata;

  triple_lens_ray_hit_test_unit u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the register file
  logic [MassW-1:0] lens_mass [NumLens];
  logic [PosW-1:0]  lens_pos [NumLens];
  logic [EnvW-1:0]  env_rad_sq;

  flags_t hit_flags_q[$];
  int     errors = 0;
  int     beats_in = 0, beats_out = 0, hits_seen = 0, sats_seen = 0;
  int     tx_gap_max = 16, rx_gap_max = 16;
  bit     rx_hold_req = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > longint'(TermMax)) return longint'(TermMax);
    if (v < -longint'(TermMax) - 1) return -longint'(TermMax) - 1;
    return v;
  endfunction

  // one axis of a deflection term: sign(d) * floor(m*|d| / d2), clamped
  function automatic longint axis_deflection(longint m, longint d, logic [63:0] d2,
                                             inout bit sat);
    logic [63:0] mag, q;
    if (d == 0 || m == 0) return 0;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    if (d2 == 0) q = 64'(TermMax);
    else begin
      q = (64'(m) * mag) / d2;
      if (q > 64'(TermMax)) begin
        q = 64'(TermMax);
        sat = 1'b1;
      end
    end
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // lens equation: image position minus the three deflection terms, full width
  function automatic void map_ray(input logic [31:0] px_b, py_b, output longint zx, zy,
                                  output bit sat);
    longint px, py, m, dx, dy;
    logic [63:0] d2;
    px = longint'($signed(px_b));
    py = longint'($signed(py_b));
    zx = px;
    zy = py;
    sat = 1'b0;
    for (int i = 0; i < NumLens; i++) begin
      m  = (lens_mass[i] > MassOne) ? longint'(MassOne) : longint'(lens_mass[i]);
      dx = clamp32(px - longint'($signed(lens_pos[i][63:32])));
      dy = clamp32(py - longint'($signed(lens_pos[i][31:0])));
      d2 = (64'(dx * dx) + 64'(dy * dy)) >> FracBits;
      if (d2 == 0 && m != 0) sat = 1'b1;
      zx -= axis_deflection(m, dx, d2, sat);
      zy -= axis_deflection(m, dy, d2, sat);
    end
  endfunction

  function automatic flags_t predict_hit(logic [31:0] px, py, sx, sy);
    longint zx, zy, ex, ey;
    logic [63:0] ax, ay, a, b, lim;
    flags_t f;
    bit sat;
    map_ray(px, py, zx, zy, sat);
    f.sat = sat;
    f.hit = 1'b0;
    ex = zx - longint'($signed(sx));
    ey = zy - longint'($signed(sy));
    if (ex > -64'sh1_0000_0000 && ex < 64'sh1_0000_0000 &&
        ey > -64'sh1_0000_0000 && ey < 64'sh1_0000_0000) begin
      ax  = (ex < 0) ? 64'(-ex) : 64'(ex);
      ay  = (ey < 0) ? 64'(-ey) : 64'(ey);
      lim = 64'(env_rad_sq) << FracBits;
      a   = ax * ax;
      b   = ay * ay;
      f.hit = (a <= lim && b <= lim && a + b <= lim);
    end
    return f;
  endfunction

  // one write beat, then the enable drops again before the next write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PosW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (cfg_idx_e'(idx))
      CfgMassOne:   lens_mass[0] = val[MassW-1:0];
      CfgMassTwo:   lens_mass[1] = val[MassW-1:0];
      CfgMassThree: lens_mass[2] = val[MassW-1:0];
      CfgLensOne:   lens_pos[0]  = val;
      CfgLensTwo:   lens_pos[1]  = val;
      CfgLensThree: lens_pos[2]  = val;
      CfgEnvRadSq:  env_rad_sq   = val[EnvW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one input beat; expectation is queued as the handshake is seen
  task automatic send_pixel(logic [31:0] px, py, sx, sy, bit typed, flags_t flags);
    int gap;
    bit rdy;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sy, sx, py, px};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    hit_flags_q = {hit_flags_q, (typed ? flags : predict_hit(px, py, sx, sy))};
    beats_in++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (hit_flags_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // masses at and beyond 1.0, zero and random; lenses near the origin, in the last phase anywhere
  task automatic load_lens_setup(int phase);
    logic [MassW-1:0] m;
    logic [EnvW-1:0]  env;
    for (int i = 0; i < NumLens; i++) begin
      case ((phase + i) % 5)
        0: m = '0;
        1: m = MassOne;
        2: m = '1;  // above 1.0, used as 1.0
        3: m = MassW'($urandom_range(0, 1 << 22));
        default: m = MassW'($urandom_range(0, 1 << 25));
      endcase
      write_reg(CfgIdxW'(CfgMassOne + i), 64'(m));
      write_reg(CfgIdxW'(CfgLensOne + i), (phase == Phases - 1) ? {$urandom, $urandom}
                                : {rand_coord(1 << 25), rand_coord(1 << 25)});
    end
    case (phase % 4)
      0: env = '0;
      1: env = '1;
      2: env = 32'($urandom_range(0, 1 << 20));
      default: env = $urandom;
    endcase
    write_reg(CfgEnvRadSq, 64'(env));
    write_reg(CfgIdxSpare, {$urandom, $urandom});
  endtask

  // random pixel: full range noise, near a lens, or aimed near its own image
  task automatic send_random_pixel();
    logic [31:0] px, py, sx, sy;
    longint zx, zy;
    bit sat;
    int sel, k;
    sel = $urandom_range(0, 9);
    k   = $urandom_range(0, NumLens - 1);
    if (sel < 2) begin
      px = $urandom; py = $urandom; sx = $urandom; sy = $urandom;
    end else begin
      if (sel < 4) begin
        px = lens_pos[k][63:32] + rand_coord(1 << $urandom_range(0, 20));
        py = lens_pos[k][31:0] + rand_coord(1 << $urandom_range(0, 20));
      end else begin
        px = rand_coord(1 << 26);
        py = rand_coord(1 << 26);
      end
      map_ray(px, py, zx, zy, sat);
      sx = 32'(clamp32(zx + longint'($signed(rand_coord(1 << $urandom_range(4, 24))))));
      sy = 32'(clamp32(zy + longint'($signed(rand_coord(1 << $urandom_range(4, 24))))));
    end
    send_pixel(px, py, sx, sy, 1'b0, '0);
  endtask

  // result checker: handshake seen at the falling edge, checked at the rising one
  bit         out_beat = 1'b0;
  logic [7:0] out_data;
  always @(negedge clk_i) begin
    out_beat = m_axis_tvalid && m_axis_tready && rst_ni;
    out_data = m_axis_tdata;
  end
  always @(posedge clk_i) begin
    flags_t want;
    if (out_beat) begin
      beats_out++;
      hits_seen += out_data[0];
      sats_seen += out_data[1];
      if (hit_flags_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = hit_flags_q.pop_front();
        if (out_data[0] !== want.hit) begin
          $error("hit: expected %b got %b", want.hit, out_data[0]);
          errors++;
        end
        if (out_data[1] !== want.sat) begin
          $error("saturated: expected %b got %b", want.sat, out_data[1]);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls per beat, plus one long hold on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  pixel_row_t directed[$];

  initial begin
    lens_mass  = '{MassOne, '0, '0};
    lens_pos   = '{'0, '0, '0};
    env_rad_sq = '0;
    // reset values: unit mass at the origin, zero envelope
    directed = '{
      '{32'h0, 32'h0, 32'h0, 32'h0, 1, '{1'b1, 1'b1}},               // pixel on the lens
      '{32'h0100_0000, 32'h0, 32'h0, 32'h0, 1, '{1'b1, 1'b0}},       // Einstein ring
      '{32'h0, 32'h1, 32'h0, 32'h0, 1, '{1'b0, 1'b1}},               // d2 truncates to zero
      '{32'h1000, 32'h0, 32'h0, 32'h0, 0, '0},                       // term overflow
      '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, '0},
      '{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 0, '0},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0},
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '0},
      '{32'h0200_0000, 32'hfe00_0000, 32'h0180_0000, 32'hfe80_0000, 0, '0},
      '{32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1, '{1'b0, 1'b1}}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_pixel(directed[i].px, directed[i].py, directed[i].sx, directed[i].sy,
                 directed[i].typed, directed[i].flags);
    drain();
    // far lens: every pixel difference clamps
    write_reg(CfgLensOne, {32'h8000_0000, 32'h8000_0000});
    write_reg(CfgEnvRadSq, 64'hffff_ffff);
    for (int i = 0; i < 6; i++)
      send_pixel({1'b0, 31'($urandom)}, {1'b0, 31'($urandom)}, $urandom, $urandom, 0, '0);
    drain();

    for (int p = 0; p < Phases; p++) begin
      load_lens_setup(p);
      tx_gap_max = (p % 3 == 1 || p == 3) ? 0 : 16;
      rx_gap_max = (p % 3 == 2) ? 0 : 16;
      if (p == 3) rx_hold_req = 1'b1;  // backs the pipe up into the input
      for (int i = 0; i < PhaseItems; i++) begin
        send_random_pixel();
        if (p == 5 && i == PhaseItems / 2) drain();  // sender waits for an empty pipe
      end
      drain();
    end

    $display("Covered %0d pixel beats over %0d lens setups, all register indexes.",
             beats_in, Phases + 2);
    $display("Results: %0d beats, %0d hits, %0d saturated.", beats_out, hits_seen,
             sats_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
